// File: rtl/ptw_pkg.sv
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types and constants of the page table walker: field widths, command
// codes, the queue item passed from front to back and the result item.
// ----------------------------------------------------------------------------
package ptw_pkg;

    localparam int VA_W    = 48;
    localparam int ADDR_W  = 52;
    localparam int ENTRY_W = 64;
    localparam int PA_W    = 49;
    localparam int IDX_W   = 9;

    // Frame bits of an entry (mask 0xFFFFFFFFF000)
    localparam int FRAME_LO = 12;
    localparam int FRAME_HI = 47;

    // Entry flag bits
    localparam int BIT_PRESENT  = 0;
    localparam int BIT_WRITABLE = 1;
    localparam int BIT_LARGE    = 7;
    localparam int BIT_NX       = 63;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [1:0] {
        CMD_TRANSLATE = 2'd0,
        CMD_MAKE_WX   = 2'd1,
        CMD_ENTRY     = 2'd2
    } cmd_t;

    // Classified item: a start carries the first entry address in word
    typedef struct packed {
        logic               is_start;
        logic               make_wx;
        logic [VA_W-1:0]    va;
        logic [ENTRY_W-1:0] word;
    } ptw_item_t;

    typedef struct packed {
        logic              walk_done;
        logic [ADDR_W-1:0] read_address;
        logic              write_enable;
        logic [ADDR_W-1:0] write_address;
        logic [ENTRY_W-1:0] write_data;
        logic [PA_W-1:0]   translated_address;
        logic              fault;
    } ptw_result_t;

endpackage

// File: rtl/ptw_front.sv
// ----------------------------------------------------------------------------
// ptw_front
// Accepts input items, drops unknown commands and classifies the rest. A walk
// start gets its top-level entry address computed here.
// ----------------------------------------------------------------------------
module ptw_front
    import ptw_pkg::*;
(
    input  logic [1:0]         command,
    input  logic [VA_W-1:0]    virtual_address,
    input  logic [ADDR_W-1:0]  table_root,
    input  logic [ENTRY_W-1:0] entry_data,
    input  logic               accept,
    output logic               push,
    output ptw_item_t          item
);

    logic [ADDR_W-1:0] top_addr;

    // Compute root plus eight times the top index, wrapping at the address width
    assign top_addr = table_root
                    + {{(ADDR_W-IDX_W-3){1'b0}}, virtual_address[47:39], 3'b000};

    // Classify the item and push it unless the command is unknown
    always_comb
    begin
        push          = 1'b0;
        item.is_start = 1'b0;
        item.make_wx  = 1'b0;
        item.va       = virtual_address;
        item.word     = entry_data;
        case (command)
            CMD_TRANSLATE, CMD_MAKE_WX:
            begin
                push          = accept;
                item.is_start = 1'b1;
                item.make_wx  = (command == CMD_MAKE_WX);
                item.word     = {{(ENTRY_W-ADDR_W){1'b0}}, top_addr};
            end
            CMD_ENTRY:
            begin
                push = accept;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/ptw_queue.sv
// ----------------------------------------------------------------------------
// ptw_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module ptw_queue
    import ptw_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  ptw_item_t push_item,
    input  logic      pop,
    output logic      not_empty,
    output logic      full,
    output ptw_item_t head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ptw_item_t           slot_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign head_item = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap at the last slot
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Hold pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/ptw_back.sv
// ----------------------------------------------------------------------------
// ptw_back
// Carries out the walk: holds the walk state, checks each returned entry and
// loads one result item per queue item into the output register.
// ----------------------------------------------------------------------------
module ptw_back
    import ptw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_not_empty,
    input  ptw_item_t   q_item,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output ptw_result_t result
);

    typedef enum logic [2:0] {
        LVL_IDLE  = 3'd0,
        LVL_TOP   = 3'd1,
        LVL_THIRD = 3'd2,
        LVL_DIR   = 3'd3,
        LVL_TABLE = 3'd4
    } level_t;

    level_t            level_reg, level_next;
    logic              kind_reg, kind_next;
    logic [VA_W-1:0]   va_reg, va_next;
    logic [ADDR_W-1:0] last_reg, last_next;
    logic              out_valid_reg, out_valid_next;
    ptw_result_t       result_reg, result_next;

    logic [ENTRY_W-1:0] entry;
    logic [IDX_W-1:0]   next_idx;
    logic [PA_W-1:0]    pa_large;
    logic [PA_W-1:0]    pa_small;

    // Pick the nine index bits of the virtual address for a level
    function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                     input level_t lvl);
        logic [IDX_W-1:0] idx;
        case (lvl)
            LVL_TOP:   idx = va[47:39];
            LVL_THIRD: idx = va[38:30];
            LVL_DIR:   idx = va[29:21];
            LVL_TABLE: idx = va[20:12];
            default:   idx = va[47:39];
        endcase
        return idx;
    endfunction

    assign entry     = q_item.word;
    assign pop       = q_not_empty && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // Form both leaf addresses: large pages overlap offset and frame bits
    assign pa_large = {1'b0, entry[FRAME_HI:FRAME_LO], 12'h000}
                    + {{(PA_W-21){1'b0}}, va_reg[20:0]};
    assign pa_small = {1'b0, entry[FRAME_HI:FRAME_LO], va_reg[11:0]};

    assign next_idx = level_index(va_reg, level_t'(level_reg + 3'd1));

    // Decide the next walk state and the result of the popped item
    always_comb
    begin
        level_next     = level_reg;
        kind_next      = kind_reg;
        va_next        = va_reg;
        last_next      = last_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (pop)
        begin
            out_valid_next = 1'b1;
            result_next    = '0;
            if (q_item.is_start)
            begin
                level_next               = LVL_TOP;
                kind_next                = q_item.make_wx;
                va_next                  = q_item.va;
                last_next                = q_item.word[ADDR_W-1:0];
                result_next.read_address = q_item.word[ADDR_W-1:0];
            end
            else if (level_reg == LVL_IDLE || !entry[BIT_PRESENT])
            begin
                level_next            = LVL_IDLE;
                result_next.walk_done = 1'b1;
                result_next.fault     = 1'b1;
            end
            else if ((level_reg == LVL_DIR && entry[BIT_LARGE]) || level_reg == LVL_TABLE)
            begin
                level_next            = LVL_IDLE;
                result_next.walk_done = 1'b1;
                if (kind_reg)
                begin
                    result_next.write_enable  = 1'b1;
                    result_next.write_address = last_reg;
                    result_next.write_data    = {1'b0, entry[ENTRY_W-2:2], 1'b1, entry[0]};
                end
                else
                begin
                    result_next.translated_address = (level_reg == LVL_DIR) ? pa_large
                                                                            : pa_small;
                end
            end
            else
            begin
                level_next = level_t'(level_reg + 3'd1);
                // Low twelve frame bits are zero, so the index just concatenates
                last_next  = {{(ADDR_W-48){1'b0}}, entry[FRAME_HI:FRAME_LO],
                              next_idx, 3'b000};
                result_next.read_address = {{(ADDR_W-48){1'b0}},
                                            entry[FRAME_HI:FRAME_LO], next_idx, 3'b000};
            end
        end
    end

    // Hold walk state and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= LVL_IDLE;
            kind_reg      <= 1'b0;
            va_reg        <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            level_reg     <= level_next;
            kind_reg      <= kind_next;
            va_reg        <= va_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            result_reg    <= result_next;
        end
    end

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !pop)
        else $error("result overwritten while stalled");

    // A missing entry ends the walk
    a_fault_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !q_item.is_start && !entry[BIT_PRESENT]) |=> (level_reg == LVL_IDLE))
        else $error("walk continues after a fault");

    // A start always issues the top-level read
    a_start_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_item.is_start) |=> (out_valid_reg && !result_reg.walk_done
                                      && level_reg == LVL_TOP))
        else $error("start without top-level read");

    // Read requests carry no write-back and no translation
    a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_reg.walk_done) |-> (!result_reg.write_enable
            && !result_reg.fault && result_reg.translated_address == '0))
        else $error("read request carries leaf fields");

    // A faulted result has no write-back
    a_fault_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.fault) |-> (result_reg.walk_done
                                                 && !result_reg.write_enable))
        else $error("fault with write-back");

endmodule

// File: rtl/page_table_walker.sv
// ----------------------------------------------------------------------------
// page_table_walker
// Four-level page table walker that reaches memory through its own channels.
//
//   Channel  Handshake            Payload
//   in       in_valid/in_stall    command, virtual_address, table_root,
//                                 entry_data
//   out      out_valid/out_stall  walk_done, read_address, write_enable,
//                                 write_address, write_data,
//                                 translated_address, fault
//
// One item per cycle in steady state while neither stall is raised; each known
// command gives one result on the output (the item is written into a queue
// slot, then loads the output register when the back pops it).
// Reset leaves the walker idle and the queue empty; no clearing pass.
// in_stall rises only when the front/back queue is full.
// out_stall holds the output register and lets the queue fill behind it.
// ----------------------------------------------------------------------------
module page_table_walker
    import ptw_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic [VA_W-1:0]    virtual_address,
    input  logic [ADDR_W-1:0]  table_root,
    input  logic [ENTRY_W-1:0] entry_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               walk_done,
    output logic [ADDR_W-1:0]  read_address,
    output logic               write_enable,
    output logic [ADDR_W-1:0]  write_address,
    output logic [ENTRY_W-1:0] write_data,
    output logic [PA_W-1:0]    translated_address,
    output logic               fault
);

    logic        accept;
    logic        push;
    logic        pop;
    logic        q_not_empty;
    logic        q_full;
    ptw_item_t   push_item;
    ptw_item_t   head_item;
    ptw_result_t result;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    ptw_front u_front (
        .command         (command),
        .virtual_address (virtual_address),
        .table_root      (table_root),
        .entry_data      (entry_data),
        .accept          (accept),
        .push            (push),
        .item            (push_item)
    );

    ptw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .not_empty (q_not_empty),
        .full      (q_full),
        .head_item (head_item)
    );

    ptw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_item      (head_item),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result      (result)
    );

    // Unpack the result item onto the ports
    assign walk_done          = result.walk_done;
    assign read_address       = result.read_address;
    assign write_enable       = result.write_enable;
    assign write_address      = result.write_address;
    assign write_data         = result.write_data;
    assign translated_address = result.translated_address;
    assign fault              = result.fault;

endmodule
